// File: rtl/lzbr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lzbr_pkg
// Shared constants, codes and types of the LZ back-reference copy core.
// ----------------------------------------------------------------------------
package lzbr_pkg;

  // history window: 2**HIST_AW bytes, circular
  localparam int HIST_AW       = 16;
  localparam int HISTORY_BYTES = 1 << HIST_AW;

  // match record queue
  localparam int MQ_AW    = 2;
  localparam int MQ_DEPTH = 1 << MQ_AW;

  // queue of classified beats between front and back
  localparam int OPQ_AW    = 2;
  localparam int OPQ_DEPTH = 1 << OPQ_AW;

  localparam int POS_W  = 32;
  localparam int DIST_W = 17;

  localparam logic REQ_MATCH = 1'b0;
  localparam logic REQ_BYTE  = 1'b1;

  typedef enum logic [1:0] {
    ERR_NONE       = 2'd0,
    ERR_QUEUE_FULL = 2'd1,
    ERR_BAD_DIST   = 2'd2,
    ERR_STALE      = 2'd3
  } err_t;

  // one classified item, as handed from the front to the back
  typedef struct packed {
    logic               is_byte;
    logic [7:0]         byte_val;
    logic [POS_W-1:0]   pos;
    logic               copy;
    logic [HIST_AW-1:0] rd_addr;
    err_t               err;
  } op_t;

endpackage
`default_nettype wire

// File: rtl/lzbr_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lzbr_in_if
// Request channel: match records and data bytes.
// ----------------------------------------------------------------------------
interface lzbr_in_if;
  import lzbr_pkg::*;

  logic                valid;
  logic                ready;
  logic                req_type;
  logic [7:0]          data_byte;
  logic [POS_W-1:0]    match_start;
  logic [POS_W-1:0]    match_end;
  logic [DIST_W-1:0]   match_distance;

  modport source (output valid, req_type, data_byte, match_start, match_end,
                  match_distance, input ready);
  modport sink   (input valid, req_type, data_byte, match_start, match_end,
                  match_distance, output ready);
endinterface
`default_nettype wire

// File: rtl/lzbr_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lzbr_out_if
// Result channel: one result beat per request beat.
// ----------------------------------------------------------------------------
interface lzbr_out_if;
  import lzbr_pkg::*;

  logic             valid;
  logic             ready;
  logic             byte_valid;
  logic [7:0]       out_byte;
  logic [POS_W-1:0] out_position;
  logic             from_match;
  logic [1:0]       error_code;

  modport source (output valid, byte_valid, out_byte, out_position, from_match,
                  error_code, input ready);
  modport sink   (input valid, byte_valid, out_byte, out_position, from_match,
                  error_code, output ready);
endinterface
`default_nettype wire

// File: rtl/lzbr_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lzbr_front
// Accepts request beats, keeps the stream position and the match record
// queue, and turns each beat into a classified op for the back end.
// ----------------------------------------------------------------------------
module lzbr_front (
  input  wire logic          clk,
  input  wire logic          rst,
  lzbr_in_if.sink            req_ch,
  input  wire logic          q_full,
  output logic               op_push,
  output lzbr_pkg::op_t      op
);
  import lzbr_pkg::*;

  logic [POS_W-1:0]  q_start [MQ_DEPTH];
  logic [POS_W-1:0]  q_end   [MQ_DEPTH];
  logic [DIST_W-1:0] q_dist  [MQ_DEPTH];
  logic [MQ_AW-1:0]  head;
  logic [MQ_AW:0]    count;
  logic [POS_W-1:0]  pos;

  logic [MQ_DEPTH-1:0] lt, cov, last, dbad;
  logic [MQ_AW:0]      n_pop;
  logic [MQ_AW-1:0]    hd;
  logic [MQ_AW:0]      remain;
  logic                hit, bad, pop_last;
  logic [POS_W-1:0]    diff;
  logic [MQ_AW-1:0]    slot;
  err_t                rec_err;
  logic                accept;

  assign req_ch.ready = !q_full;
  assign accept       = req_ch.valid && req_ch.ready;
  assign op_push      = accept;

  // per-entry compares against the current position, all in parallel
  always_comb begin
    for (int i = 0; i < MQ_DEPTH; i++) begin
      lt[i]   = q_end[i] < pos;
      cov[i]  = q_start[i] <= pos;
      last[i] = q_end[i] == pos;
      dbad[i] = POS_W'(q_dist[i]) > pos;
    end
  end

  // drop passed records from the head, then look at the new head
  always_comb begin
    logic [MQ_AW-1:0] idx;
    logic             run;
    n_pop = '0;
    run   = 1'b1;
    for (int k = 0; k < MQ_DEPTH; k++) begin
      idx = head + MQ_AW'(k);
      if (run && ((MQ_AW+1)'(k) < count) && lt[idx]) begin
        n_pop = n_pop + 1'b1;
      end else begin
        run = 1'b0;
      end
    end
  end

  assign hd       = head + n_pop[MQ_AW-1:0];
  assign remain   = count - n_pop;
  assign hit      = (remain != '0) && cov[hd];
  assign bad      = hit && dbad[hd];
  assign pop_last = hit && last[hd];
  assign diff     = pos - POS_W'(q_dist[hd]);
  assign slot     = head + count[MQ_AW-1:0];

  always_comb begin
    if (req_ch.match_distance == '0 ||
        POS_W'(req_ch.match_distance) > POS_W'(HISTORY_BYTES)) begin
      rec_err = ERR_BAD_DIST;
    end else if (req_ch.match_end < req_ch.match_start || req_ch.match_end < pos) begin
      rec_err = ERR_STALE;
    end else if (count == (MQ_AW+1)'(MQ_DEPTH)) begin
      rec_err = ERR_QUEUE_FULL;
    end else begin
      rec_err = ERR_NONE;
    end
  end

  always_comb begin
    op.is_byte  = req_ch.req_type == REQ_BYTE;
    op.byte_val = op.is_byte ? req_ch.data_byte : 8'd0;
    op.pos      = op.is_byte ? pos : '0;
    op.copy     = op.is_byte && hit && !bad;
    op.rd_addr  = diff[HIST_AW-1:0];
    op.err      = op.is_byte ? (bad ? ERR_BAD_DIST : ERR_NONE) : rec_err;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      count <= '0;
      pos   <= '0;
    end else if (accept) begin
      if (req_ch.req_type == REQ_BYTE) begin
        head  <= hd + MQ_AW'(pop_last);
        count <= remain - (MQ_AW+1)'(pop_last);
        pos   <= pos + 1'b1;
      end else if (rec_err == ERR_NONE) begin
        count <= count + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && req_ch.req_type == REQ_MATCH && rec_err == ERR_NONE) begin
      q_start[slot] <= req_ch.match_start;
      q_end[slot]   <= req_ch.match_end;
      q_dist[slot]  <= req_ch.match_distance;
    end
  end

endmodule
`default_nettype wire

// File: rtl/lzbr_opq.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lzbr_opq
// Short first-in first-out queue of classified ops between front and back.
// ----------------------------------------------------------------------------
module lzbr_opq (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire lzbr_pkg::op_t push_op,
  input  wire logic          pop,
  output lzbr_pkg::op_t      head_op,
  output logic               full,
  output logic               empty
);
  import lzbr_pkg::*;

  op_t               slots [OPQ_DEPTH];
  logic [OPQ_AW-1:0] wr_ptr, rd_ptr;
  logic [OPQ_AW:0]   count;
  logic              do_pop;

  assign full    = count == (OPQ_AW+1)'(OPQ_DEPTH);
  assign empty   = count == '0;
  assign head_op = slots[rd_ptr];
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop) rd_ptr <= rd_ptr + 1'b1;
      if (push && !do_pop) begin
        count <= count + 1'b1;
      end else if (!push && do_pop) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_op;
  end

endmodule
`default_nettype wire

// File: rtl/lzbr_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lzbr_back
// Reads the history, forwards the byte being written, writes every output
// byte back and holds the result in an output register.
// ----------------------------------------------------------------------------
module lzbr_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire lzbr_pkg::op_t head_op,
  input  wire logic          q_empty,
  output logic               q_pop,
  lzbr_out_if.source         res_ch
);
  import lzbr_pkg::*;

  logic [7:0] history [HISTORY_BYTES];

  // read stage
  logic       b_valid;
  op_t        b_op;
  logic [7:0] rd_q;
  logic       b_byp;
  logic [7:0] b_byp_val;
  logic [7:0] b_value;

  // output register
  logic             o_valid;
  logic             o_byte_valid;
  logic [7:0]       o_byte;
  logic [POS_W-1:0] o_pos;
  logic             o_from_match;
  err_t             o_err;

  logic o_free, b_adv, b_take;

  assign o_free = !o_valid || res_ch.ready;
  assign b_adv  = b_valid && o_free;
  assign b_take = !q_empty && (!b_valid || b_adv);
  assign q_pop  = b_take;

  assign b_value = !b_op.copy ? b_op.byte_val : (b_byp ? b_byp_val : rd_q);

  // the read sees memory before the write at the same edge: forward that one
  always_ff @(posedge clk) begin
    if (b_take) begin
      rd_q      <= history[head_op.rd_addr];
      b_byp     <= b_adv && b_op.is_byte && (b_op.pos[HIST_AW-1:0] == head_op.rd_addr);
      b_byp_val <= b_value;
      b_op      <= head_op;
    end
    if (b_adv && b_op.is_byte) begin
      history[b_op.pos[HIST_AW-1:0]] <= b_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
      o_valid <= 1'b0;
    end else begin
      if (b_take) begin
        b_valid <= 1'b1;
      end else if (b_adv) begin
        b_valid <= 1'b0;
      end
      if (b_adv) begin
        o_valid <= 1'b1;
      end else if (res_ch.ready) begin
        o_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (b_adv) begin
      o_byte_valid <= b_op.is_byte;
      o_byte       <= b_value;
      o_pos        <= b_op.pos;
      o_from_match <= b_op.copy;
      o_err        <= b_op.err;
    end
  end

  assign res_ch.valid        = o_valid;
  assign res_ch.byte_valid   = o_byte_valid;
  assign res_ch.out_byte     = o_byte;
  assign res_ch.out_position = o_pos;
  assign res_ch.from_match   = o_from_match;
  assign res_ch.error_code   = o_err;

endmodule
`default_nettype wire

// File: rtl/lz_back_reference_copy_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lz_back_reference_copy_core
// Fills LZ back-references into a literal byte stream from a 64 KiB history.
// ----------------------------------------------------------------------------
//   channel  dir  beat
//   req_ch   in   match record (start, end, distance) or one data byte
//   res_ch   out  one result per request: byte, position, copy flag, error
//
// One request beat per cycle while the op queue is not full, records and
// bytes alike; a result passes the op queue, the read stage and the output
// register. The history memory has one write and one registered read port;
// a copy at distance one is forwarded. Reset clears position, record queue
// and pipeline; the history is not cleared and needs no pass. A four-deep op
// queue decouples the request side from result stalls.
// ----------------------------------------------------------------------------
module lz_back_reference_copy_core (
  input  wire logic  clk,
  input  wire logic  rst,
  lzbr_in_if.sink    req_ch,
  lzbr_out_if.source res_ch
);
  import lzbr_pkg::*;

  op_t  push_op, head_op;
  logic push, pop, full, empty;

  lzbr_front u_front (
    .clk     (clk),
    .rst     (rst),
    .req_ch  (req_ch),
    .q_full  (full),
    .op_push (push),
    .op      (push_op)
  );

  lzbr_opq u_opq (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_op (push_op),
    .pop     (pop),
    .head_op (head_op),
    .full    (full),
    .empty   (empty)
  );

  lzbr_back u_back (
    .clk     (clk),
    .rst     (rst),
    .head_op (head_op),
    .q_empty (empty),
    .q_pop   (pop),
    .res_ch  (res_ch)
  );

endmodule
`default_nettype wire
